// ===== hdl/rnl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnl_pkg
// Shared types, constants and the transition table of the remap name lexer.
// ----------------------------------------------------------------------------
package rnl_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned LEN_OUT_W       = 16;
  localparam int unsigned CODE_W          = 5;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned STATE_W         = 5;
  localparam int unsigned QUEUE_DEPTH     = 3;

  // lexeme codes
  localparam logic [CODE_W-1:0] LEX_TILDE_SLASH = 5'd0;
  localparam logic [CODE_W-1:0] LEX_URL_SERVICE = 5'd1;
  localparam logic [CODE_W-1:0] LEX_URL_TOPIC   = 5'd2;
  localparam logic [CODE_W-1:0] LEX_COLON       = 5'd3;
  localparam logic [CODE_W-1:0] LEX_NODE        = 5'd4;
  localparam logic [CODE_W-1:0] LEX_NS          = 5'd5;
  localparam logic [CODE_W-1:0] LEX_SEPARATOR   = 5'd6;
  localparam logic [CODE_W-1:0] LEX_BR1         = 5'd7;
  localparam logic [CODE_W-1:0] LEX_TOKEN       = 5'd16;
  localparam logic [CODE_W-1:0] LEX_SLASH       = 5'd17;
  localparam logic [CODE_W-1:0] LEX_WILD_ONE    = 5'd18;
  localparam logic [CODE_W-1:0] LEX_WILD_MULTI  = 5'd19;
  localparam logic [CODE_W-1:0] LEX_EOF         = 5'd20;
  localparam logic [CODE_W-1:0] LEX_NONE        = 5'd21;
  localparam logic [CODE_W-1:0] LEX_DOT         = 5'd22;

  // dfa start state
  localparam logic [STATE_W-1:0] ST_START = 5'd0;

  // what a state does with a byte that matches none of its ranges
  typedef enum logic [1:0] {
    MOVE_TAKE,    // consume it (a zero byte is read again instead)
    MOVE_RETRY,   // read it again
    MOVE_BACK1,   // hand back one consumed byte, read both again
    MOVE_BACK2    // hand back two consumed bytes, read all three again
  } move_t;

  // one transition memory word
  typedef struct packed {
    logic               eof;   // end byte at lexeme start
    logic               hit;   // byte matched a range
    logic               fin;   // dst is a lexeme code, not a state
    logic [STATE_W-1:0] dst;
    move_t              move;
  } rnl_entry_t;

  // one finished lexeme on its way to the output register
  typedef struct packed {
    logic                 valid;
    logic [CODE_W-1:0]    code;
    logic [LEN_OUT_W-1:0] length;
    logic                 last;
  } rnl_res_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_STEP
  } seq_state_t;

  function automatic rnl_entry_t rnl_fallback(input logic fin, input logic [STATE_W-1:0] dst,
                                              input move_t move);
    rnl_entry_t e;
    e.eof  = 1'b0;
    e.hit  = 1'b0;
    e.fin  = fin;
    e.dst  = dst;
    e.move = move;
    return e;
  endfunction

  function automatic rnl_entry_t rnl_take(input rnl_entry_t e_in, input logic fin,
                                          input logic [STATE_W-1:0] dst);
    rnl_entry_t e;
    e     = e_in;
    e.hit = 1'b1;
    e.fin = fin;
    e.dst = dst;
    return e;
  endfunction

  // transition table: first matching range wins, else the state's fallback
  function automatic rnl_entry_t rnl_lookup(input logic [STATE_W-1:0] st,
                                            input logic [BYTE_W-1:0] b);
    rnl_entry_t e;
    logic       lower;
    logic       upper;
    logic       digit;
    lower = (b >= "a") && (b <= "z");
    upper = (b >= "A") && (b <= "Z");
    digit = (b >= "0") && (b <= "9");
    e     = rnl_fallback(1'b1, LEX_NONE, MOVE_TAKE);
    case (st)
      5'd0: begin
        if (b == "/") e = rnl_take(e, 1'b1, LEX_SLASH);
        else if (b == ".") e = rnl_take(e, 1'b1, LEX_DOT);
        else if (b == 8'h5C) e = rnl_take(e, 1'b0, 5'd1);
        else if (b == "~") e = rnl_take(e, 1'b0, 5'd2);
        else if (b == "_") e = rnl_take(e, 1'b0, 5'd3);
        else if (b == "r") e = rnl_take(e, 1'b0, 5'd11);
        else if (lower || upper) e = rnl_take(e, 1'b0, 5'd9);
        else if (b == "*") e = rnl_take(e, 1'b0, 5'd30);
        else if (b == ":") e = rnl_take(e, 1'b0, 5'd31);
      end
      5'd1: begin
        if (b inside {["1":"9"]}) e = rnl_take(e, 1'b1, LEX_BR1 + 5'(b[3:0]) - 5'd1);
      end
      5'd2: if (b == "/") e = rnl_take(e, 1'b1, LEX_TILDE_SLASH);
      5'd3: begin
        e = rnl_fallback(1'b0, 5'd10, MOVE_RETRY);
        if (b == "_") e = rnl_take(e, 1'b0, 5'd4);
      end
      5'd4: if (b == "n") e = rnl_take(e, 1'b0, 5'd5);
      5'd5: begin
        if (b == "s") e = rnl_take(e, 1'b1, LEX_NS);
        else if (b == "o") e = rnl_take(e, 1'b0, 5'd6);
        else if (b == "a") e = rnl_take(e, 1'b0, 5'd7);
      end
      5'd6: if (b == "d") e = rnl_take(e, 1'b0, 5'd8);
      5'd7: if (b == "m") e = rnl_take(e, 1'b0, 5'd8);
      5'd8: if (b == "e") e = rnl_take(e, 1'b1, LEX_NODE);
      5'd9: begin
        e = rnl_fallback(1'b1, LEX_TOKEN, MOVE_RETRY);
        if (lower || upper || digit) e = rnl_take(e, 1'b0, 5'd9);
        else if (b == "_") e = rnl_take(e, 1'b0, 5'd10);
      end
      5'd10: begin
        e = rnl_fallback(1'b1, LEX_TOKEN, MOVE_RETRY);
        if (lower || upper || digit) e = rnl_take(e, 1'b0, 5'd9);
      end
      5'd11: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "o") e = rnl_take(e, 1'b0, 5'd12);
      end
      5'd12: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "s") e = rnl_take(e, 1'b0, 5'd13);
      end
      5'd13: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "t") e = rnl_take(e, 1'b0, 5'd14);
        else if (b == "s") e = rnl_take(e, 1'b0, 5'd21);
      end
      5'd14: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "o") e = rnl_take(e, 1'b0, 5'd15);
      end
      5'd15: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "p") e = rnl_take(e, 1'b0, 5'd16);
      end
      5'd16: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "i") e = rnl_take(e, 1'b0, 5'd17);
      end
      5'd17: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "c") e = rnl_take(e, 1'b0, 5'd18);
      end
      5'd18: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == ":") e = rnl_take(e, 1'b0, 5'd19);
      end
      5'd19: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_BACK1);
        if (b == "/") e = rnl_take(e, 1'b0, 5'd20);
      end
      5'd20: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_BACK2);
        if (b == "/") e = rnl_take(e, 1'b1, LEX_URL_TOPIC);
      end
      5'd21: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "e") e = rnl_take(e, 1'b0, 5'd22);
      end
      5'd22: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "r") e = rnl_take(e, 1'b0, 5'd23);
      end
      5'd23: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "v") e = rnl_take(e, 1'b0, 5'd24);
      end
      5'd24: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "i") e = rnl_take(e, 1'b0, 5'd25);
      end
      5'd25: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "c") e = rnl_take(e, 1'b0, 5'd26);
      end
      5'd26: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == "e") e = rnl_take(e, 1'b0, 5'd27);
      end
      5'd27: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_RETRY);
        if (b == ":") e = rnl_take(e, 1'b0, 5'd28);
      end
      5'd28: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_BACK1);
        if (b == "/") e = rnl_take(e, 1'b0, 5'd29);
      end
      5'd29: begin
        e = rnl_fallback(1'b0, 5'd9, MOVE_BACK2);
        if (b == "/") e = rnl_take(e, 1'b1, LEX_URL_SERVICE);
      end
      5'd30: begin
        e = rnl_fallback(1'b1, LEX_WILD_ONE, MOVE_RETRY);
        if (b == "*") e = rnl_take(e, 1'b1, LEX_WILD_MULTI);
      end
      5'd31: begin
        e = rnl_fallback(1'b1, LEX_COLON, MOVE_RETRY);
        if (b == "=") e = rnl_take(e, 1'b1, LEX_SEPARATOR);
      end
      default: e = rnl_fallback(1'b1, LEX_NONE, MOVE_TAKE);
    endcase
    e.eof = (st == ST_START) && (b == '0);
    return e;
  endfunction

endpackage

// ===== hdl/rnl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnl_if
// Valid/ready channels of the remap name lexer: text bytes in, lexemes out.
// ----------------------------------------------------------------------------
interface rnl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface rnl_lexeme_if;
  logic        valid;
  logic        ready;
  logic [4:0]  lexeme_code;
  logic [15:0] lexeme_length;
  logic        is_last;

  modport source (output valid, output lexeme_code, output lexeme_length, output is_last,
                  input ready);
  modport sink (input valid, input lexeme_code, input lexeme_length, input is_last,
                output ready);
endinterface

// ===== hdl/rnl_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnl_rom
// Transition memory: state and byte in, registered transition word out in the
// next cycle. The word holds while no new read is issued.
// ----------------------------------------------------------------------------
module rnl_rom (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rnl_pkg::STATE_W-1:0]  st,
  input  logic [rnl_pkg::BYTE_W-1:0]   text_byte,
  output rnl_pkg::rnl_entry_t          data
);
  import rnl_pkg::*;

  // synchronous read port
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rnl_lookup(st, text_byte);
    end
  end

endmodule

// ===== hdl/rnl_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnl_out
// Output register for finished lexemes; takes a new one in the cycle the
// held one transfers.
// ----------------------------------------------------------------------------
module rnl_out (
  input  logic              clk,
  input  logic              rst,
  input  rnl_pkg::rnl_res_t res,
  output logic              can_push,
  rnl_lexeme_if.source      lex_out
);
  import rnl_pkg::*;

  logic                 valid;
  logic [CODE_W-1:0]    code;
  logic [LEN_OUT_W-1:0] length;
  logic                 last;

  assign can_push = !valid || lex_out.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_push) begin
      valid <= res.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_push && res.valid) begin
      code   <= res.code;
      length <= res.length;
      last   <= res.last;
    end
  end

  assign lex_out.valid         = valid;
  assign lex_out.lexeme_code   = code;
  assign lex_out.lexeme_length = length;
  assign lex_out.is_last       = last;

endmodule

// ===== hdl/remap_name_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remap_name_lexer
// Streaming lexer for name-remapping rules, one text byte per transfer.
// ----------------------------------------------------------------------------
// Each text byte is looked up in a transition memory with a registered read,
// and the result is applied in the step that follows, so a byte is first
// accepted and then has its transition applied. Every byte that a state
// leaves to be read again or hands back is run through another step (the
// longest replay is a two-byte backup after "rostopic:/" or "rosservice:/"),
// and a step that finishes a lexeme waits while the output register holds an
// untaken lexeme. A byte of 0 at a lexeme start gives the eof lexeme with
// is_last set and returns the lexer to its start. Lengths saturate at
// 2**LENGTH_BITS - 1 and are shown in 16 bits.
// ----------------------------------------------------------------------------
module remap_name_lexer #(
  parameter int unsigned LENGTH_BITS = rnl_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rnl_byte_if.sink      text_in,
  rnl_lexeme_if.source  lex_out
);
  import rnl_pkg::*;

  localparam int unsigned LenW = LENGTH_BITS;

  seq_state_t         seq, seq_next;
  logic [STATE_W-1:0] dfa_state, dfa_state_next;
  logic [LenW-1:0]    count, count_next;
  logic [1:0]         qn, qn_next;
  logic [BYTE_W-1:0]  hist0, hist0_next;
  logic [BYTE_W-1:0]  hist1, hist1_next;
  logic [BYTE_W-1:0]  cur, cur_next;
  logic [BYTE_W-1:0]  queue      [QUEUE_DEPTH];
  logic [BYTE_W-1:0]  queue_next [QUEUE_DEPTH];

  logic               rom_en;
  logic [STATE_W-1:0] rom_st;
  logic [BYTE_W-1:0]  rom_byte;
  rnl_entry_t         ent;

  rnl_res_t           res;
  logic               can_push;

  logic               in_xfer;
  logic               consume;
  logic               emit;
  logic               stall;
  logic               more;
  logic [1:0]         requeue;
  logic [2:0]         total;
  logic [LenW-1:0]    count_adj;
  logic [BYTE_W-1:0]  l0, l1, l2;
  logic [BYTE_W-1:0]  head;
  logic [BYTE_W-1:0]  rem [QUEUE_DEPTH];
  logic [LenW+LEN_OUT_W-1:0] len_ext;

  rnl_rom u_rom (
    .clk       (clk),
    .en        (rom_en),
    .st        (rom_st),
    .text_byte (rom_byte),
    .data      (ent)
  );

  rnl_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .can_push (can_push),
    .lex_out  (lex_out)
  );

  assign text_in.ready = (seq == SEQ_IDLE);
  assign in_xfer       = text_in.valid && text_in.ready;

  // step decode: consume or hand back, build the replay list
  always_comb begin
    consume   = ent.hit || ((ent.move == MOVE_TAKE) && (cur != '0));
    count_adj = count;
    requeue   = 2'd0;
    l0        = cur;
    l1        = cur;
    l2        = cur;
    if (consume) begin
      count_adj = (count == '1) ? count : count + LenW'(1);
    end else begin
      case (ent.move)
        MOVE_TAKE, MOVE_RETRY: begin
          requeue = 2'd1;
        end
        MOVE_BACK1: begin
          requeue   = 2'd2;
          count_adj = (count == '0) ? '0 : count - LenW'(1);
          l0        = hist1;
        end
        MOVE_BACK2: begin
          requeue   = 2'd3;
          count_adj = (count < LenW'(2)) ? '0 : count - LenW'(2);
          l0        = hist0;
          l1        = hist1;
        end
        default: requeue = 2'd0;
      endcase
    end
    // replayed bytes go in front of what is still queued
    case (requeue)
      2'd0: begin
        head   = queue[0];
        rem[0] = queue[1];
        rem[1] = queue[2];
        rem[2] = queue[2];
      end
      2'd1: begin
        head   = l0;
        rem[0] = queue[0];
        rem[1] = queue[1];
        rem[2] = queue[2];
      end
      2'd2: begin
        head   = l0;
        rem[0] = l1;
        rem[1] = queue[0];
        rem[2] = queue[1];
      end
      default: begin
        head   = l0;
        rem[0] = l1;
        rem[1] = l2;
        rem[2] = queue[0];
      end
    endcase
    total   = {1'b0, qn} + {1'b0, requeue};
    emit    = ent.eof || ent.fin;
    stall   = emit && !can_push;
    more    = !ent.eof && (total != '0);
    len_ext = {{LEN_OUT_W{1'b0}}, count_adj};
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    case (seq)
      SEQ_IDLE: if (in_xfer) seq_next = SEQ_STEP;
      SEQ_STEP: if (!stall && !more) seq_next = SEQ_IDLE;
      default:  seq_next = SEQ_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    dfa_state_next = dfa_state;
    count_next     = count;
    qn_next        = qn;
    hist0_next     = hist0;
    hist1_next     = hist1;
    cur_next       = cur;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_next[i] = queue[i];
    end
    rom_en   = 1'b0;
    rom_st   = dfa_state;
    rom_byte = text_in.text_byte;
    res      = '0;
    case (seq)
      SEQ_IDLE: begin
        if (in_xfer) begin
          cur_next = text_in.text_byte;
          qn_next  = 2'd0;
          rom_en   = 1'b1;
        end
      end
      SEQ_STEP: begin
        if (!stall) begin
          if (ent.eof) begin
            res.valid      = 1'b1;
            res.code       = LEX_EOF;
            res.length     = '0;
            res.last       = 1'b1;
            dfa_state_next = ST_START;
            count_next     = '0;
            qn_next        = 2'd0;
          end else begin
            if (consume) begin
              hist0_next = hist1;
              hist1_next = cur;
            end else if (ent.move == MOVE_BACK1) begin
              hist1_next = hist0;
            end
            if (ent.fin) begin
              res.valid      = 1'b1;
              res.code       = ent.dst;
              res.length     = len_ext[LEN_OUT_W-1:0];
              res.last       = 1'b0;
              dfa_state_next = ST_START;
              count_next     = '0;
            end else begin
              dfa_state_next = ent.dst;
              count_next     = count_adj;
            end
            // next byte from the replay queue
            if (more) begin
              cur_next = head;
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                queue_next[i] = rem[i];
              end
              qn_next  = (total > 3'd4) ? 2'd3 : 2'(total - 3'd1);
              rom_en   = 1'b1;
              rom_st   = dfa_state_next;
              rom_byte = head;
            end
          end
        end
      end
      default: rom_en = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_IDLE;
      dfa_state <= ST_START;
      count     <= '0;
      qn        <= 2'd0;
    end else begin
      seq       <= seq_next;
      dfa_state <= dfa_state_next;
      count     <= count_next;
      qn        <= qn_next;
    end
  end

  // byte registers
  always_ff @(posedge clk) begin
    hist0 <= hist0_next;
    hist1 <= hist1_next;
    cur   <= cur_next;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

`ifndef NO_ASSERTIONS
  // eof sends the lexer back to its start
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last && can_push) |=>
      (seq == SEQ_IDLE) && (dfa_state == ST_START) && (count == '0))
    else $error("eof did not return the lexer to start");

  // a new lexeme has no length yet
  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    ((seq == SEQ_IDLE) && (dfa_state == ST_START)) |-> (count == '0))
    else $error("start state with nonzero length");

  // replays never stack more than two waiting bytes
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (qn != 2'd3))
    else $error("replay queue overflow");

  // a step blocked by the output register changes nothing
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ((seq == SEQ_STEP) && stall) |=>
      $stable(dfa_state) && $stable(count) && (seq == SEQ_STEP))
    else $error("stalled step modified lexer state");
`endif

endmodule
